// ----- rtl/cgk4r_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cgk4r_pkg
// Shared types and codes for the Cayley graph K4 Ramsey check block.
// ----------------------------------------------------------------------------
package cgk4r_pkg;

    localparam int ELEM_W  = 6;
    localparam int MASK_W  = 64;
    localparam int ORDER_W = 7;
    localparam int CMD_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PROD  = 2'd0,
        CMD_INV   = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ELEM_W-1:0] left_elem;
        logic [ELEM_W-1:0] right_elem;
        logic [ELEM_W-1:0] entry_value;
        logic [MASK_W-1:0] set_mask;
    } req_t;

    typedef struct packed {
        logic k4_in_set;
        logic k4_in_complement;
        logic ramsey_ok;
    } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/cgk4r_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cgk4r_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cgk4r_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cayley_graph_k4_ramsey_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cayley_graph_k4_ramsey_check
// Loads a group's product and inverse tables, then checks a connection set and
// its complement for four mutually adjacent members on the Cayley graph.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------
//  req     | in  | req_valid / req_ready | cgk4r_pkg::req_t
//  rsp     | out | rsp_valid / rsp_ready | cgk4r_pkg::rsp_t (check items only)
//  cfg     | in  | cfg_valid / cfg_ready | group_order, 7 bits
//
//  A check builds an adjacency row per element into the row RAM: an empty
//  row for a non-member, one product RAM read per candidate for a member,
//  then a clique search that fetches rows from the row RAM. A set without
//  a K4 runs a second pass on the complement.
//  Reset clears control only; table contents are undefined until written.
//  A finished result waits in the output register; new items are taken
//  meanwhile, and only the next check result stalls until it is taken.
// ----------------------------------------------------------------------------
module cayley_graph_k4_ramsey_check #(
    parameter int MAX_ORDER = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire cgk4r_pkg::req_t               req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output cgk4r_pkg::rsp_t                    rsp,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cgk4r_pkg::ORDER_W-1:0] cfg_data
);

    import cgk4r_pkg::*;

    localparam int EW    = $clog2(MAX_ORDER);
    localparam int CW    = $clog2(MAX_ORDER + 1);
    localparam int PAW   = $clog2(MAX_ORDER * MAX_ORDER);
    localparam int LIM_W = ELEM_W + 1;
    localparam logic [LIM_W-1:0]   ORDER_LIM = LIM_W'(MAX_ORDER);
    localparam logic [ORDER_W-1:0] ORDER_MAX = ORDER_W'(MAX_ORDER);
    localparam logic [CW-1:0]      CNT_END   = CW'(MAX_ORDER);
    localparam logic [CW-1:0]      CNT_LAST  = CW'(MAX_ORDER - 1);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_INV  = 11'b000_0000_0010,
        ST_ROW  = 11'b000_0000_0100,
        ST_WR   = 11'b000_0000_1000,
        ST_G    = 11'b000_0001_0000,
        ST_GW   = 11'b000_0010_0000,
        ST_B    = 11'b000_0100_0000,
        ST_BW   = 11'b000_1000_0000,
        ST_C    = 11'b001_0000_0000,
        ST_CW   = 11'b010_0000_0000,
        ST_FIN  = 11'b100_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        g_reg, g_next;
    logic [CW-1:0]        h_reg, h_next;
    logic                 pass_reg, pass_next;
    logic [MAX_ORDER-1:0] s_reg, s_next;
    logic [MAX_ORDER-1:0] row_reg, row_next;
    logic [MAX_ORDER-1:0] ra_reg, ra_next;
    logic [MAX_ORDER-1:0] rab_reg, rab_next;
    logic                 res_set_reg, res_set_next;
    logic                 res_comp_reg, res_comp_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [ORDER_W-1:0]   group_order_reg;

    logic [ORDER_W-1:0]   n_eff;
    logic [MAX_ORDER-1:0] range_w;
    logic [CW-1:0]        ph;
    logic                 pass_done;
    logic                 pass_found;

    logic                 p_we, p_re;
    logic [PAW-1:0]       p_waddr, p_raddr;
    logic [ELEM_W-1:0]    p_rdata;
    logic                 i_we, i_re;
    logic [EW-1:0]        i_raddr;
    logic [ELEM_W-1:0]    i_rdata;
    logic                 f_we, f_re;
    logic [EW-1:0]        f_raddr;
    logic [MAX_ORDER-1:0] f_rdata;

    function automatic logic [EW-1:0] low_bit(input logic [MAX_ORDER-1:0] v);
        logic [EW-1:0] idx;
        idx = '0;
        for (int i = MAX_ORDER - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = EW'(i);
            end
        end
        return idx;
    endfunction

    assign n_eff = (group_order_reg > ORDER_MAX) ? ORDER_MAX : group_order_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            range_w[i] = (i != 0) && (ORDER_W'(i) < n_eff);
        end
    end

    assign ph        = h_reg - CW'(1);
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    assign p_waddr = PAW'(req.left_elem) * PAW'(MAX_ORDER) + PAW'(req.right_elem);
    assign p_raddr = PAW'(i_rdata) * PAW'(MAX_ORDER) + PAW'(h_reg);

    always_comb
    begin
        state_next     = state_reg;
        g_next         = g_reg;
        h_next         = h_reg;
        pass_next      = pass_reg;
        s_next         = s_reg;
        row_next       = row_reg;
        ra_next        = ra_reg;
        rab_next       = rab_reg;
        res_set_next   = res_set_reg;
        res_comp_next  = res_comp_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        pass_done      = 1'b0;
        pass_found     = 1'b0;
        p_we           = 1'b0;
        p_re           = 1'b0;
        i_we           = 1'b0;
        i_re           = 1'b0;
        i_raddr        = g_reg[EW-1:0];
        f_we           = 1'b0;
        f_re           = 1'b0;
        f_raddr        = g_reg[EW-1:0];

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (cmd_t'(req.cmd))
                        CMD_PROD:
                        begin
                            p_we = ({1'b0, req.left_elem} < ORDER_LIM)
                                && ({1'b0, req.right_elem} < ORDER_LIM)
                                && ({1'b0, req.entry_value} < ORDER_LIM);
                        end
                        CMD_INV:
                        begin
                            i_we = ({1'b0, req.left_elem} < ORDER_LIM)
                                && ({1'b0, req.entry_value} < ORDER_LIM);
                        end
                        CMD_CHECK:
                        begin
                            s_next     = req.set_mask[MAX_ORDER-1:0] & range_w;
                            pass_next  = 1'b0;
                            g_next     = '0;
                            state_next = ST_INV;
                        end
                        CMD_NOP:
                        begin
                        end
                    endcase
                end
            end
            ST_INV:
            begin
                row_next = '0;
                h_next   = '0;
                if (s_reg[g_reg[EW-1:0]])
                begin
                    i_re       = 1'b1;
                    state_next = ST_ROW;
                end
                else
                begin
                    state_next = ST_WR;
                end
            end
            ST_ROW:
            begin
                // product data here belongs to the previous h
                if (h_reg != '0)
                begin
                    if (s_reg[ph[EW-1:0]] && (ph > g_reg)
                        && s_reg[p_rdata[EW-1:0]])
                    begin
                        row_next[ph[EW-1:0]] = 1'b1;
                    end
                end
                if (h_reg == CNT_END)
                begin
                    state_next = ST_WR;
                end
                else
                begin
                    p_re   = 1'b1;
                    h_next = h_reg + CW'(1);
                end
            end
            ST_WR:
            begin
                f_we = 1'b1;
                if (g_reg == CNT_LAST)
                begin
                    g_next     = '0;
                    state_next = ST_G;
                end
                else
                begin
                    g_next     = g_reg + CW'(1);
                    state_next = ST_INV;
                end
            end
            ST_G:
            begin
                f_re       = 1'b1;
                state_next = ST_GW;
            end
            ST_GW:
            begin
                ra_next    = f_rdata;
                state_next = ST_B;
            end
            ST_B:
            begin
                if (ra_reg == '0)
                begin
                    if (g_reg == CNT_LAST)
                    begin
                        pass_done = 1'b1;
                    end
                    else
                    begin
                        g_next     = g_reg + CW'(1);
                        state_next = ST_G;
                    end
                end
                else
                begin
                    f_re       = 1'b1;
                    f_raddr    = low_bit(ra_reg);
                    ra_next    = ra_reg & (ra_reg - MAX_ORDER'(1));
                    state_next = ST_BW;
                end
            end
            ST_BW:
            begin
                rab_next   = ra_reg & f_rdata;
                state_next = ST_C;
            end
            ST_C:
            begin
                if (rab_reg == '0)
                begin
                    state_next = ST_B;
                end
                else
                begin
                    f_re       = 1'b1;
                    f_raddr    = low_bit(rab_reg);
                    rab_next   = rab_reg & (rab_reg - MAX_ORDER'(1));
                    state_next = ST_CW;
                end
            end
            ST_CW:
            begin
                if ((rab_reg & f_rdata) != '0)
                begin
                    pass_done  = 1'b1;
                    pass_found = 1'b1;
                end
                else
                begin
                    state_next = ST_C;
                end
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.k4_in_set        = res_set_reg;
                    rsp_next.k4_in_complement = res_comp_reg;
                    rsp_next.ramsey_ok        = !res_set_reg && !res_comp_reg;
                    rsp_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (pass_done)
        begin
            if (!pass_reg && !pass_found)
            begin
                pass_next  = 1'b1;
                s_next     = ~s_reg & range_w;
                g_next     = '0;
                state_next = ST_INV;
            end
            else
            begin
                res_set_next  = !pass_reg;
                res_comp_next = pass_reg && pass_found;
                state_next    = ST_FIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rsp_valid_reg   <= 1'b0;
            group_order_reg <= ORDER_W'(64);
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                group_order_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg        <= g_next;
        h_reg        <= h_next;
        pass_reg     <= pass_next;
        s_reg        <= s_next;
        row_reg      <= row_next;
        ra_reg       <= ra_next;
        rab_reg      <= rab_next;
        res_set_reg  <= res_set_next;
        res_comp_reg <= res_comp_next;
        rsp_reg      <= rsp_next;
    end

    cgk4r_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_ORDER * MAX_ORDER)
    ) u_prod_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (req.entry_value),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    cgk4r_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_ORDER)
    ) u_inv_ram (
        .clk   (clk),
        .we    (i_we),
        .waddr (req.left_elem[EW-1:0]),
        .wdata (req.entry_value),
        .re    (i_re),
        .raddr (i_raddr),
        .rdata (i_rdata)
    );

    cgk4r_ram #(
        .WIDTH (MAX_ORDER),
        .DEPTH (MAX_ORDER)
    ) u_row_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (g_reg[EW-1:0]),
        .wdata (row_reg),
        .re    (f_re),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    a_check_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.cmd == CMD_CHECK)) |=> (state_reg == ST_INV))
        else $error("check item did not start a pass");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && rsp_valid_reg && !rsp_ready)
        |=> ((state_reg == ST_FIN) && $stable(rsp_reg)))
        else $error("pending result overwritten");

    a_flags_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!(rsp.k4_in_set && rsp.k4_in_complement)
                       && (rsp.ramsey_ok == !(rsp.k4_in_set || rsp.k4_in_complement))))
        else $error("inconsistent result flags");

    a_row_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |-> (g_reg < CNT_END))
        else $error("row write beyond order");

    a_pass_switch: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_INV) && $past(state_reg == ST_B || state_reg == ST_CW))
        |-> pass_reg)
        else $error("complement pass without flag");

endmodule

`default_nettype wire
